[src/tdq_pkg.sv]
// Package with the shared types and constants of the timer deadline queue.
`timescale 1ns / 1ps
`default_nettype none
package tdq_pkg;

  localparam int unsigned SLOTS_DEF       = 16;
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned ID_W            = 4;
  localparam int unsigned DELAY_W         = 20;
  localparam int unsigned TPU_W           = 12;
  localparam logic [TPU_W-1:0] TPU_RESET  = 12'd1;

  // Request codes.
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_STOP   = 2'd2;
  localparam logic [1:0] REQ_RESUME = 2'd3;

  // Result status codes.
  localparam logic ST_EXPIRED  = 1'b0;
  localparam logic ST_REJECTED = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [ID_W-1:0]    timer_id;
    logic [DELAY_W-1:0] delay_us;
    logic               start_req;
  } tdq_in_t;

  typedef struct packed {
    logic [ID_W-1:0] slot_out;
    logic            status;
    logic            last;
  } tdq_out_t;

endpackage
`default_nettype wire

[src/timer_deadline_queue.sv]
// Top level of the timer deadline queue: sequencer, memories and output register.
//
//  channel | ports                         | direction
//  in      | in_valid, in_ready, in_data   | request into block
//  out     | out_valid, out_ready, out_data| expiry / reject transfers
//  cfg     | cfg_valid, cfg_ready, cfg_data| ticks_per_us write
//
// An add scans the queue from the head, for each entry reading the order entry,
// reading its count and comparing; the shift then reads and writes each moved entry.
// A tick decrements every entry through the count memory (order read, count read,
// write-back); when entries expire, a second pass emits them and compacts the order
// memory. Stop and resume clear or set the running flag. Reset clears the
// queue length, the slot valid bits and the running flag. A stalled output holds
// the sequencer at each emit; idle takes a request once the output can move.
`timescale 1ns / 1ps
`default_nettype none
module timer_deadline_queue #(
  parameter int unsigned SLOTS       = tdq_pkg::SLOTS_DEF,
  parameter int unsigned COUNT_WIDTH = tdq_pkg::COUNT_WIDTH_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  tdq_pkg::tdq_in_t         in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output tdq_pkg::tdq_out_t        out_data,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire [tdq_pkg::TPU_W-1:0] cfg_data
);
  import tdq_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned PW = DELAY_W + TPU_W;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_ASCAN = 9'b000000100,
    S_ACMP  = 9'b000001000,
    S_SHIFT = 9'b000010000,
    S_TDEC  = 9'b000100000,
    S_TWB   = 9'b001000000,
    S_TEXP  = 9'b010000000,
    S_TCOMP = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Memories: remaining count by slot, slot handle by queue position.
  logic [COUNT_WIDTH-1:0] cnt_mem [SLOTS];
  logic [IW-1:0]          ord_mem [SLOTS];
  logic [COUNT_WIDTH-1:0] cnt_rd_r;
  logic [IW-1:0]          ord_rd_r;
  logic                   cnt_we, ord_we;
  logic [IW-1:0]          cnt_wa, cnt_ra, ord_wa, ord_ra;
  logic [COUNT_WIDTH-1:0] cnt_wd;
  logic [IW-1:0]          ord_wd;

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    cnt_rd_r <= cnt_mem[cnt_ra];
    ord_rd_r <= ord_mem[ord_ra];
  end

  // Control and working registers.
  logic [CW-1:0]          qcnt_r, qcnt_nxt;
  logic [SLOTS-1:0]       valid_r, valid_nxt;
  logic                   run_r, run_nxt;
  logic [TPU_W-1:0]       tpu_r;
  logic [CW-1:0]          pos_r, pos_nxt;
  logic [CW-1:0]          wp_r, wp_nxt;
  logic [CW-1:0]          nexp_r, nexp_nxt;
  logic                   exp_r, exp_nxt;
  logic [COUNT_WIDTH-1:0] ticks_r, ticks_nxt;
  logic [PW-1:0]          prod_r;
  logic [IW-1:0]          id_r, id_nxt;
  logic                   start_r, start_nxt;
  logic [IW-1:0]          prev_r, prev_nxt;
  logic                   have_prev_r, have_prev_nxt;
  logic                   ov_r, ov_nxt;
  tdq_out_t               od_r, od_nxt;

  logic id_ok, reject;
  logic [COUNT_WIDTH-1:0] sat;
  logic [COUNT_WIDTH-1:0] dec;

  assign in_ready  = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    id_ok = ({{(32-ID_W){1'b0}}, in_data.timer_id} < 32'(SLOTS));
    reject = !id_ok || (qcnt_r == SLOTS_C) || valid_r[IW'(in_data.timer_id)];
  end

  // Saturate the product to the count width.
  always_comb begin
    if (PW > COUNT_WIDTH) begin
      sat = ((prod_r >> COUNT_WIDTH) != '0) ? '1 : COUNT_WIDTH'(prod_r);
    end else begin
      sat = COUNT_WIDTH'(prod_r);
    end
    dec = (cnt_rd_r != '0) ? cnt_rd_r - 1'b1 : cnt_rd_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(in_data.delay_us) * PW'(tpu_r);
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    qcnt_nxt = qcnt_r;
    valid_nxt = valid_r;
    run_nxt = run_r;
    pos_nxt = pos_r;
    wp_nxt = wp_r;
    nexp_nxt = nexp_r;
    exp_nxt = exp_r;
    ticks_nxt = ticks_r;
    id_nxt = id_r;
    start_nxt = start_r;
    prev_nxt = prev_r;
    have_prev_nxt = have_prev_r;
    ov_nxt = ov_r;
    od_nxt = od_r;
    cnt_we = 1'b0; cnt_wa = id_r; cnt_wd = ticks_r; cnt_ra = '0;
    ord_we = 1'b0; ord_wa = '0; ord_wd = id_r; ord_ra = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_data.req_type)
            REQ_ADD: begin
              if (reject) begin
                ov_nxt = 1'b1;
                od_nxt.slot_out = in_data.timer_id;
                od_nxt.status = ST_REJECTED;
                od_nxt.last = 1'b1;
              end else begin
                id_nxt = IW'(in_data.timer_id);
                start_nxt = in_data.start_req;
                state_nxt = S_MUL;
              end
            end
            REQ_TICK: begin
              if (run_r && qcnt_r != '0) begin
                pos_nxt = '0;
                nexp_nxt = '0;
                state_nxt = S_TDEC;
              end
            end
            REQ_STOP: run_nxt = 1'b0;
            default:  run_nxt = 1'b1;
          endcase
        end
      end
      // Product is registered; start the insert scan.
      S_MUL: begin
        ticks_nxt = sat;
        pos_nxt = '0;
        state_nxt = S_ASCAN;
      end
      // Read order entry at pos.
      S_ASCAN: begin
        if (pos_r == qcnt_r) begin
          wp_nxt = qcnt_r;
          state_nxt = S_SHIFT;
        end else begin
          ord_ra = pos_r[IW-1:0];
          state_nxt = S_ACMP;
        end
      end
      S_ACMP: begin
        cnt_ra = ord_rd_r;
        state_nxt = S_TWB;
        exp_nxt = 1'b0;
      end
      // Compare count of the entry at pos (shared with tick write-back state).
      S_TWB: begin
        if (have_prev_r) begin
          // Tick write-back of the decremented entry; count those now at zero.
          cnt_we = 1'b1; cnt_wa = prev_r; cnt_wd = dec;
          if (dec == '0) nexp_nxt = nexp_r + 1'b1;
          have_prev_nxt = 1'b0;
          pos_nxt = pos_r + 1'b1;
          state_nxt = S_TDEC;
        end else if (cnt_rd_r <= ticks_r) begin
          pos_nxt = pos_r + 1'b1;
          state_nxt = S_ASCAN;
        end else begin
          wp_nxt = qcnt_r;
          state_nxt = S_SHIFT;
        end
      end
      // Shift entries up one from the end down to pos, then insert.
      S_SHIFT: begin
        if (wp_r == pos_r) begin
          ord_we = 1'b1; ord_wa = pos_r[IW-1:0]; ord_wd = id_r;
          cnt_we = 1'b1; cnt_wa = id_r; cnt_wd = ticks_r;
          qcnt_nxt = qcnt_r + 1'b1;
          valid_nxt[id_r] = 1'b1;
          run_nxt = start_r;
          state_nxt = S_IDLE;
        end else if (!exp_r) begin
          ord_ra = IW'(wp_r - 1'b1);
          exp_nxt = 1'b1;
        end else begin
          ord_we = 1'b1; ord_wa = wp_r[IW-1:0]; ord_wd = ord_rd_r;
          wp_nxt = wp_r - 1'b1;
          exp_nxt = 1'b0;
        end
      end
      // Tick pass one: read order, then count, then write back.
      S_TDEC: begin
        if (!have_prev_r && !exp_r) begin
          if (pos_r == qcnt_r) begin
            pos_nxt = '0;
            wp_nxt = '0;
            state_nxt = (nexp_r == '0) ? S_IDLE : S_TEXP;
          end else begin
            ord_ra = pos_r[IW-1:0];
            exp_nxt = 1'b1;
          end
        end else begin
          cnt_ra = ord_rd_r;
          prev_nxt = ord_rd_r;
          have_prev_nxt = 1'b1;
          exp_nxt = 1'b0;
          state_nxt = S_TWB;
        end
      end
      // Tick pass two: read each order entry once the output can take a result.
      S_TEXP: begin
        if (!ov_r || out_ready) begin
          if (pos_r == qcnt_r) begin
            qcnt_nxt = wp_r;
            state_nxt = S_IDLE;
          end else begin
            ord_ra = pos_r[IW-1:0];
            state_nxt = S_TCOMP;
          end
        end
      end
      // Zero counts form the head of the queue: emit those, compact the rest.
      S_TCOMP: begin
        if (pos_r < nexp_r) begin
          valid_nxt[ord_rd_r] = 1'b0;
          ov_nxt = 1'b1;
          od_nxt.slot_out = ID_W'(ord_rd_r);
          od_nxt.status = ST_EXPIRED;
          od_nxt.last = (pos_r + 1'b1 == nexp_r);
        end else begin
          ord_we = 1'b1; ord_wa = wp_r[IW-1:0]; ord_wd = ord_rd_r;
          wp_nxt = wp_r + 1'b1;
        end
        pos_nxt = pos_r + 1'b1;
        state_nxt = S_TEXP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      qcnt_r <= '0;
      valid_r <= '0;
      run_r <= 1'b0;
      ov_r <= 1'b0;
      tpu_r <= TPU_RESET;
      have_prev_r <= 1'b0;
      exp_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      qcnt_r <= qcnt_nxt;
      valid_r <= valid_nxt;
      run_r <= run_nxt;
      ov_r <= ov_nxt;
      have_prev_r <= have_prev_nxt;
      exp_r <= exp_nxt;
      if (cfg_valid && cfg_ready) tpu_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    wp_r <= wp_nxt;
    nexp_r <= nexp_nxt;
    ticks_r <= ticks_nxt;
    id_r <= id_nxt;
    start_r <= start_nxt;
    prev_r <= prev_nxt;
    od_r <= od_nxt;
  end

endmodule
`default_nettype wire
